// ===== src/prg_pkg.sv =====
// Shared constants, types and codes for the peak row grouper.
package prg_pkg;

  localparam int MAX_ROWS    = 256;
  localparam int MAX_SAMPLES = 64;
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int CNT_W       = ROW_W + 1;
  localparam int SAMPLE_W    = 6;
  localparam int INDEX_W     = 8;
  localparam int WORD_W      = 32;
  localparam int MTOL_W      = 14;
  localparam int CHARGE_W    = 6;
  localparam int CFG_IDX_W   = 2;

  // mass half width = floor(mass * tol / 1e7); 1e7 = 2^7 * 5^7, so the product
  // drops 7 bits and is multiplied by ceil(2^55 / 5^7), exact below 2^39
  localparam int PROD_W      = WORD_W + MTOL_W;
  localparam int QUOT_W      = 24;
  localparam int PRE_SHIFT   = 7;
  localparam int RECIP_W     = 39;
  localparam int RECIP_SHIFT = 55;
  localparam int PART_W      = 20;
  localparam int PAIR_W      = 2 * PART_W;
  localparam int ACC_W       = RECIP_SHIFT + QUOT_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(64'd461168601843);

  localparam logic [CFG_IDX_W-1:0] REG_MASS_TOL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TIME_TOL = CFG_IDX_W'(1);

  localparam logic [MTOL_W-1:0] MASS_TOL_RESET = MTOL_W'(100);
  localparam logic [WORD_W-1:0] TIME_TOL_RESET = WORD_W'(32768);

  typedef enum logic [1:0] {
    OUT_JOINED = 2'd0,
    OUT_NEW    = 2'd1,
    OUT_DUP    = 2'd2,
    OUT_FULL   = 2'd3
  } outcome_t;

  typedef struct packed {
    logic [WORD_W-1:0]      mass_lo;
    logic [WORD_W-1:0]      mass_hi;
    logic [WORD_W-1:0]      time_lo;
    logic [WORD_W-1:0]      time_hi;
    logic [CHARGE_W-1:0]    charge;
    logic [MAX_SAMPLES-1:0] members;
  } row_t;

endpackage

// ===== src/prg_div.sv =====
// Division by the fixed mass divisor: reciprocal multiply, four partial products on one multiplier.
module prg_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [prg_pkg::PROD_W-1:0]    dividend,
  output logic                          busy,
  output logic [prg_pkg::QUOT_W-1:0]    quotient
);

  logic [1:0]                   phase;
  logic                         run;
  logic [prg_pkg::PAIR_W-1:0]   scaled;
  logic [prg_pkg::PAIR_W-1:0]   recip;
  logic [prg_pkg::PART_W-1:0]   op_a;
  logic [prg_pkg::PART_W-1:0]   op_b;
  logic [prg_pkg::PAIR_W-1:0]   part;
  logic [prg_pkg::ACC_W-1:0]    part_sh;
  logic [prg_pkg::ACC_W-1:0]    acc;

  assign recip = prg_pkg::PAIR_W'(prg_pkg::RECIP);

  // phase bit 1 picks the high half of the scaled product, bit 0 that of the reciprocal
  assign op_a = phase[1] ? scaled[prg_pkg::PAIR_W-1:prg_pkg::PART_W]
                         : scaled[prg_pkg::PART_W-1:0];
  assign op_b = phase[0] ? recip[prg_pkg::PAIR_W-1:prg_pkg::PART_W]
                         : recip[prg_pkg::PART_W-1:0];
  assign part = prg_pkg::PAIR_W'(op_a) * prg_pkg::PAIR_W'(op_b);

  always_comb begin
    part_sh = prg_pkg::ACC_W'(part);
    if (phase[1]) begin
      part_sh = part_sh << prg_pkg::PART_W;
    end
    if (phase[0]) begin
      part_sh = part_sh << prg_pkg::PART_W;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      phase <= '0;
    end else if (start) begin
      run   <= 1'b1;
      phase <= '0;
    end else if (run) begin
      phase <= phase + 2'd1;
      if (phase == 2'd3) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      scaled <= prg_pkg::PAIR_W'(dividend[prg_pkg::PROD_W-1:prg_pkg::PRE_SHIFT]);
      acc    <= '0;
    end else if (run) begin
      acc <= acc + part_sh;
    end
  end

  assign busy     = run;
  assign quotient = acc[prg_pkg::RECIP_SHIFT +: prg_pkg::QUOT_W];

endmodule

// ===== src/peak_row_grouper.sv =====
// Peak row grouper: sorts peaks into a table of rows by charge, mass and time windows.
//
//   channel  dir  handshake              payload
//   in       in   in_valid / in_stall    peak_mass, peak_time, charge_state, sample_number
//   out      out  out_valid / out_stall  outcome, row_index
//   cfg      in   cfg_write              cfg_index, cfg_data
//
// Rows are checked one per cycle through the registered read port. A peak that stops
// at row r (joined or duplicate) is answered once row r is checked; a scan of all n
// rows answers full when the table is full, else a new row is written once the mass
// window multiply that runs alongside the scan is done. A new peak is taken only
// after the answer to the last one has been issued.
// Reset empties the table at once (rows_used goes to zero); no clearing pass.
// A held output word stalls the block only when the next result is ready.
module peak_row_grouper (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [prg_pkg::WORD_W-1:0]          peak_mass,
  input  logic [prg_pkg::WORD_W-1:0]          peak_time,
  input  logic signed [prg_pkg::CHARGE_W-1:0] charge_state,
  input  logic [prg_pkg::SAMPLE_W-1:0]        sample_number,
  output logic                                out_valid,
  input  logic                                out_stall,
  output prg_pkg::outcome_t                   outcome,
  output logic [prg_pkg::INDEX_W-1:0]         row_index,
  input  logic                                cfg_write,
  input  logic [prg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [prg_pkg::WORD_W-1:0]          cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_WRITE,
    S_EMIT
  } state_t;

  state_t state;

  logic [prg_pkg::MTOL_W-1:0]      mass_tol;
  logic [prg_pkg::WORD_W-1:0]      time_tol;

  logic [prg_pkg::WORD_W-1:0]      mass;
  logic [prg_pkg::WORD_W-1:0]      ptime;
  logic [prg_pkg::CHARGE_W-1:0]    charge;
  logic [prg_pkg::MAX_SAMPLES-1:0] sample_bit;

  logic [prg_pkg::CNT_W-1:0]       rows_used;
  logic [prg_pkg::CNT_W-1:0]       fetch_idx;
  logic [prg_pkg::ROW_W-1:0]       chk_idx;
  logic                            chk_vld;
  logic                            primed;

  prg_pkg::outcome_t               res_outcome;
  logic [prg_pkg::INDEX_W-1:0]     res_row;

  prg_pkg::row_t                   mem [prg_pkg::MAX_ROWS];
  prg_pkg::row_t                   rd_data;
  prg_pkg::row_t                   new_row;
  prg_pkg::row_t                   mem_wdata;
  logic [prg_pkg::ROW_W-1:0]       mem_waddr;
  logic                            mem_we;

  logic                            in_take;
  logic                            hit;
  logic                            dup;
  logic                            table_full;
  logic                            div_busy;
  logic [prg_pkg::QUOT_W-1:0]      half;
  logic [prg_pkg::PROD_W-1:0]      product;
  logic [prg_pkg::WORD_W:0]        mass_sum;
  logic [prg_pkg::WORD_W:0]        time_sum;

  assign in_stall   = state != S_IDLE;
  assign in_take    = in_valid && !in_stall;
  assign table_full = rows_used == prg_pkg::CNT_W'(prg_pkg::MAX_ROWS);

  always_ff @(posedge clk) begin
    if (rst) begin
      mass_tol <= prg_pkg::MASS_TOL_RESET;
      time_tol <= prg_pkg::TIME_TOL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        prg_pkg::REG_MASS_TOL: mass_tol <= cfg_data[prg_pkg::MTOL_W-1:0];
        prg_pkg::REG_TIME_TOL: time_tol <= cfg_data;
        default: ;
      endcase
    end
  end

  assign product = prg_pkg::PROD_W'(peak_mass) * prg_pkg::PROD_W'(mass_tol);

  prg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (in_take),
    .dividend (product),
    .busy     (div_busy),
    .quotient (half)
  );

  // row under test: rd_data holds entry chk_idx when chk_vld
  assign hit = chk_vld && primed &&
               rd_data.charge == charge &&
               mass >= rd_data.mass_lo && mass <= rd_data.mass_hi &&
               ptime >= rd_data.time_lo && ptime <= rd_data.time_hi;
  assign dup = (rd_data.members & sample_bit) != '0;

  // window bounds, saturated at both ends
  assign mass_sum = {1'b0, mass} + (prg_pkg::WORD_W + 1)'(half);
  assign time_sum = {1'b0, ptime} + {1'b0, time_tol};

  always_comb begin
    new_row.mass_lo = (prg_pkg::WORD_W'(half) >= mass) ? '0 : mass - prg_pkg::WORD_W'(half);
    new_row.mass_hi = mass_sum[prg_pkg::WORD_W] ? '1 : mass_sum[prg_pkg::WORD_W-1:0];
    new_row.time_lo = (time_tol >= ptime) ? '0 : ptime - time_tol;
    new_row.time_hi = time_sum[prg_pkg::WORD_W] ? '1 : time_sum[prg_pkg::WORD_W-1:0];
    new_row.charge  = charge;
    new_row.members = sample_bit;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = chk_idx;
    mem_wdata = rd_data;
    if (state == S_SCAN && hit && !dup) begin
      mem_we            = 1'b1;
      mem_wdata.members = rd_data.members | sample_bit;
    end else if (state == S_WRITE) begin
      mem_we    = 1'b1;
      mem_waddr = rows_used[prg_pkg::ROW_W-1:0];
      mem_wdata = new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[fetch_idx[prg_pkg::ROW_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rows_used <= '0;
      chk_vld   <= 1'b0;
      primed    <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            mass       <= peak_mass;
            ptime      <= peak_time;
            charge     <= charge_state;
            sample_bit <= prg_pkg::MAX_SAMPLES'(1) << sample_number;
            fetch_idx  <= '0;
            chk_vld    <= 1'b0;
            primed     <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          fetch_idx <= fetch_idx + prg_pkg::CNT_W'(1);
          chk_idx   <= fetch_idx[prg_pkg::ROW_W-1:0];
          chk_vld   <= fetch_idx < rows_used;
          primed    <= 1'b1;
          if (hit) begin
            res_outcome <= dup ? prg_pkg::OUT_DUP : prg_pkg::OUT_JOINED;
            res_row     <= dup ? '0 : prg_pkg::INDEX_W'(chk_idx);
            state       <= S_EMIT;
          end else if (primed && !chk_vld) begin
            if (table_full) begin
              res_outcome <= prg_pkg::OUT_FULL;
              res_row     <= '0;
              state       <= S_EMIT;
            end else begin
              state <= div_busy ? S_WAIT : S_WRITE;
            end
          end
        end
        S_WAIT: begin
          if (!div_busy) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          res_outcome <= prg_pkg::OUT_NEW;
          res_row     <= prg_pkg::INDEX_W'(rows_used);
          rows_used   <= rows_used + prg_pkg::CNT_W'(1);
          state       <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            outcome   <= res_outcome;
            row_index <= res_row;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_rows_bound: assert property (@(posedge clk) disable iff (rst)
    rows_used <= prg_pkg::CNT_W'(prg_pkg::MAX_ROWS))
    else $error("row count beyond table size");

  a_rows_grow: assert property (@(posedge clk) disable iff (rst)
    (state != S_WRITE) |=> $stable(rows_used))
    else $error("row count moved outside row creation");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> !div_busy)
    else $error("new row written before mass window is ready");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_SCAN || state == S_WRITE))
    else $error("table written outside scan or create");

  a_zero_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && (outcome == prg_pkg::OUT_DUP || outcome == prg_pkg::OUT_FULL)
      |-> row_index == '0)
    else $error("nonzero row index on rejected word");
`endif

endmodule
